### sv/sliding_window_frame_detector_macros.svh
// Assertion macros used by swfd_checker.sv.
`ifndef SLIDING_WINDOW_FRAME_DETECTOR_MACROS_SVH
`define SLIDING_WINDOW_FRAME_DETECTOR_MACROS_SVH

// Clocked assertion, masked while reset is asserted.
`define SWFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define SWFD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/swfd_pkg.sv
`timescale 1ns / 1ps
package swfd_pkg;

  localparam int PAYLOAD_BYTES_DEF = 20;
  localparam int IDX_OUT_W         = 6;
  localparam logic [7:0] START_MARK = 8'hFF;

  // window -> top: a frame sits in the window and waits for the emitter
  typedef struct packed {
    logic hit;
  } win_stat_t;

  // emitter -> top
  typedef struct packed {
    logic can_load;
  } emit_stat_t;

endpackage

### sv/swfd_ifs.sv
`timescale 1ns / 1ps
interface swfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface swfd_result_if;
  import swfd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [7:0]           msg_code;
  logic [IDX_OUT_W-1:0] byte_index;
  logic [7:0]           payload_byte;
  logic                 last_byte;

  modport source (output valid, output msg_code, output byte_index,
                  output payload_byte, output last_byte, input ready);
  modport sink (input valid, input msg_code, input byte_index,
                input payload_byte, input last_byte, output ready);
endinterface

### sv/swfd_window.sv
`timescale 1ns / 1ps
module swfd_window #(
  parameter int PAYLOAD_BYTES = swfd_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic [7:0]                    din,
  input  logic                          grant,
  output swfd_pkg::win_stat_t           stat,
  output logic [7:0]                    code,
  output logic [PAYLOAD_BYTES-1:0][7:0] payload
);
  import swfd_pkg::*;

  localparam int WIN_LEN    = 2 + PAYLOAD_BYTES + 1 + (PAYLOAD_BYTES / 2);
  localparam int CHECK_BASE = 2 + PAYLOAD_BYTES + 1;
  localparam int PAIRS      = PAYLOAD_BYTES / 2;

  // element 0 is the oldest byte
  logic [WIN_LEN-1:0][7:0] win_r, win_nxt;
  logic                    pend_r, pend_nxt;
  logic [PAIRS-1:0]        chk;
  logic                    frame_ok;

  always_comb begin
    for (int j = 0; j < PAIRS; j++) begin
      chk[j] = ((win_r[2 + 2 * j] ^ win_r[3 + 2 * j]) == win_r[CHECK_BASE + j]);
    end
  end

  assign frame_ok = (win_r[0] == START_MARK) && (&chk) && (win_r[1] != 8'd0);

  assign stat.hit  = pend_r && frame_ok;
  assign code      = win_r[1];
  assign payload   = win_r[PAYLOAD_BYTES+1:2];

  always_comb begin
    win_nxt  = shift_en ? {din, win_r[WIN_LEN-1:1]} : win_r;
    // a detected frame stays pending until the emitter takes it
    pend_nxt = shift_en || (stat.hit && !grant);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      win_r  <= win_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule

### sv/swfd_emitter.sv
`timescale 1ns / 1ps
module swfd_emitter #(
  parameter int PAYLOAD_BYTES = swfd_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          load,
  input  logic [7:0]                    code,
  input  logic [PAYLOAD_BYTES-1:0][7:0] payload,
  output swfd_pkg::emit_stat_t          stat,
  swfd_result_if.source                 out_ch
);
  import swfd_pkg::*;

  localparam int IDX_W = $clog2(PAYLOAD_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PAYLOAD_BYTES - 1);

  logic                          busy_r, busy_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [7:0]                    code_r, code_nxt;
  logic [PAYLOAD_BYTES-1:0][7:0] buf_r, buf_nxt;
  logic                          at_last;
  logic                          xfer;

  assign at_last = (idx_r == LAST_IDX);
  assign xfer    = busy_r && out_ch.ready;

  assign stat.can_load = !busy_r || (xfer && at_last);

  assign out_ch.valid        = busy_r;
  assign out_ch.msg_code     = code_r;
  assign out_ch.byte_index   = IDX_OUT_W'(idx_r);
  assign out_ch.payload_byte = buf_r[0];
  assign out_ch.last_byte    = at_last;

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    code_nxt = code_r;
    buf_nxt  = buf_r;
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      code_nxt = code;
      buf_nxt  = payload;
    end else if (xfer) begin
      // shift the next payload byte into the output slot
      buf_nxt = {8'd0, buf_r[PAYLOAD_BYTES-1:1]};
      idx_nxt = idx_r + 1'b1;
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    buf_r  <= buf_nxt;
  end

endmodule

### sv/sliding_window_frame_detector.sv
// channel | dir | payload                                           | role
// in_ch   | in  | rx_byte[7:0]                                      | received bytes
// out_ch  | out | msg_code[7:0] byte_index[5:0] payload_byte[7:0]   | frame payload,
//         |     | last_byte                                         | one byte per transfer
//
// A byte is taken every cycle while in_ch.ready is high and shifts the window, checked in
// the next cycle. A matching frame loads the output buffer, then PAYLOAD_BYTES transfers
// follow, one per cycle while out_ch.ready is high; the buffer reloads on the last one.
// in_ch.ready drops only while a matched frame waits for a busy output buffer.
// rst_n (synchronous) clears the window to zero and empties the output buffer.
`timescale 1ns / 1ps
module sliding_window_frame_detector #(
  parameter int PAYLOAD_BYTES = swfd_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  swfd_byte_if.sink    in_ch,
  swfd_result_if.source out_ch
);
  import swfd_pkg::*;

  win_stat_t                     win_stat;
  emit_stat_t                    emit_stat;
  logic [7:0]                    code;
  logic [PAYLOAD_BYTES-1:0][7:0] payload;
  logic                          load;
  logic                          in_xfer;

  assign load        = win_stat.hit && emit_stat.can_load;
  assign in_ch.ready = !(win_stat.hit && !emit_stat.can_load);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  swfd_window #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (in_xfer),
    .din      (in_ch.rx_byte),
    .grant    (emit_stat.can_load),
    .stat     (win_stat),
    .code     (code),
    .payload  (payload)
  );

  swfd_emitter #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_emitter (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (load),
    .code    (code),
    .payload (payload),
    .stat    (emit_stat),
    .out_ch  (out_ch)
  );

endmodule

### sv/swfd_checker.sv
`timescale 1ns / 1ps
`include "sliding_window_frame_detector_macros.svh"
module swfd_checker #(
  parameter int PAYLOAD_BYTES = swfd_pkg::PAYLOAD_BYTES_DEF
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [7:0]                     out_msg_code,
  input logic [swfd_pkg::IDX_OUT_W-1:0] out_byte_index,
  input logic [7:0]                     out_payload_byte,
  input logic                           out_last_byte
);
  import swfd_pkg::*;

  localparam logic [IDX_OUT_W-1:0] LAST_IDX = IDX_OUT_W'(PAYLOAD_BYTES - 1);

  `SWFD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_payload_byte) && $stable(out_byte_index), "stalled result changed")
  `SWFD_ASSERT(a_run_step, out_valid && out_ready && !out_last_byte |=> out_valid && $stable(out_msg_code) && (out_byte_index == IDX_OUT_W'($past(out_byte_index) + 1'b1)), "payload run broken")
  `SWFD_ASSERT(a_last_idx, out_valid && out_last_byte |-> out_byte_index == LAST_IDX, "last flag at wrong index")
  `SWFD_ASSERT(a_new_run, out_valid && out_ready && out_last_byte |=> !out_valid || (out_byte_index == '0), "new run does not start at index zero")
  `SWFD_ASSERT_RST(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind sliding_window_frame_detector swfd_checker #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_msg_code     (out_ch.msg_code),
  .out_byte_index   (out_ch.byte_index),
  .out_payload_byte (out_ch.payload_byte),
  .out_last_byte    (out_ch.last_byte)
);
